### rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and helpers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    localparam int SIZE_BITS       = 32;
    localparam int COUNT_BITS      = 32;
    localparam int LINE_BITS       = 12;
    localparam int SIZE_LIM_BITS   = 8;
    localparam int CFG_DATA_BITS   = 12;
    localparam int STATUS_BITS     = 3;
    localparam int OUT_FIELD_BITS  = 8 + STATUS_BITS + 32;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_CLOSE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_BUSY     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DONE     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_LONG     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BADCRLF  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_CLOSED   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 3'd5;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    localparam logic CFG_SIZE_LIMIT    = 1'b0;
    localparam logic CFG_TRAILER_LIMIT = 1'b1;

    localparam logic [SIZE_LIM_BITS-1:0] SIZE_LIMIT_RST    = 8'd63;
    localparam logic [LINE_BITS-1:0]     TRAILER_LIMIT_RST = 12'd4095;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_CRLF,
        PH_TRAILER,
        PH_DONE,
        PH_FAIL
    } t_phase;

    // classified stream item, as queued between front and back
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_item;

    typedef struct packed {
        logic [SIZE_LIM_BITS-1:0] size_limit;
        logic [LINE_BITS-1:0]     trailer_limit;
    } t_limits;

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic is_dec;
        logic is_alpha;
        is_dec   = (b >= 8'h30) && (b <= 8'h39);
        is_alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
        if (is_dec) begin
            return {1'b1, b[3:0]};
        end else if (is_alpha) begin
            return {1'b1, b[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

endpackage

### rtl/http_chunked_decoder.sv
// An accepted item is written to the queue; its result is registered when chd_back pops it.
// Throughput: one byte item per cycle unless the output stalls; chd_back steps its parser per item.
// A 2-entry queue and the output register let input and output stall independently.
// Reset (i_rst_n low, synchronous): parser returns to the size line phase, queue and
// output empty, line limits back to 63 and 4095.
// ----------------------------------------------------------------------------
// http_chunked_decoder
// HTTP/1.1 chunked body decoder, one stream byte per item.
// ----------------------------------------------------------------------------
module http_chunked_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [chd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]                          i_s_tuser,   // [1:0] op
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [10:8] status, [42:11] bytes_written, rest zero
    output logic [chd_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    output logic                                o_m_tuser    // [0] out_valid
);
    import chd_pkg::*;

    t_limits r_limits;
    logic    q_valid;
    logic    q_ready;
    t_item   q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.size_limit    <= SIZE_LIMIT_RST;
            r_limits.trailer_limit <= TRAILER_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SIZE_LIMIT) begin
                r_limits.size_limit <= i_cfg_data[SIZE_LIM_BITS-1:0];
            end else begin
                r_limits.trailer_limit <= i_cfg_data[LINE_BITS-1:0];
            end
        end
    end

    chd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    chd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limits   (r_limits),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_item   (q_item),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### rtl/chd_front.sv
// ----------------------------------------------------------------------------
// chd_front
// Accepts stream items, classifies the byte and queues them for the back end.
// ----------------------------------------------------------------------------
module chd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]       i_s_tuser,   // [1:0] op
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output chd_pkg::t_item   o_q_item
);
    import chd_pkg::*;

    t_item                     r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic                      push;
    logic                      pop;
    t_item                     cls;
    logic [4:0]                hex;

    assign hex          = hex_decode(i_s_tdata);
    assign cls.op       = i_s_tuser;
    assign cls.data     = i_s_tdata;
    assign cls.is_cr    = (i_s_tdata == BYTE_CR);
    assign cls.is_lf    = (i_s_tdata == BYTE_LF);
    assign cls.hex_ok   = hex[4];
    assign cls.hex_val  = hex[3:0];

    assign o_s_tready = (r_count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != '0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");

    a_count_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not follow a pop");

endmodule

### rtl/chd_back.sv
// ----------------------------------------------------------------------------
// chd_back
// Chunk parser state machine with a registered result stage.
// ----------------------------------------------------------------------------
module chd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chd_pkg::t_limits                    i_limits,
    input  logic                                i_q_valid,
    output logic                                o_q_ready,
    input  chd_pkg::t_item                      i_q_item,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [10:8] status, [42:11] bytes_written, rest zero
    output logic [chd_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    output logic                                o_m_tuser   // [0] out_valid
);
    import chd_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [STATUS_BITS-1:0]  r_fail, n_fail;
    logic [LINE_BITS-1:0]    r_line_count, n_line_count;
    logic                    r_prev_cr, n_prev_cr;
    logic                    r_hex_active, n_hex_active;
    logic                    r_size_ovf, n_size_ovf;
    logic [SIZE_BITS-1:0]    r_acc, n_acc;
    logic [SIZE_BITS-1:0]    r_remaining, n_remaining;
    logic                    r_first_bad, n_first_bad;
    logic [COUNT_BITS-1:0]   r_written, n_written;

    logic                    r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;
    logic                    r_out_user;

    logic                    pop;
    logic [LINE_BITS:0]      limit;
    logic [LINE_BITS:0]      line_n;
    logic                    line_end;
    logic                    line_long;
    logic                    digit_take;
    logic                    acc_over;
    logic                    ovf_next;
    logic [SIZE_BITS-1:0]    acc_next;
    logic [SIZE_BITS-1:0]    remaining_dec;
    logic [7:0]              out_byte;
    logic                    out_flag;
    logic [STATUS_BITS-1:0]  status;

    assign o_q_ready = !r_out_valid || i_m_tready;
    assign pop       = i_q_valid && o_q_ready;

    assign limit     = (r_phase == PH_TRAILER) ? {1'b0, i_limits.trailer_limit}
                                               : (LINE_BITS+1)'(i_limits.size_limit);
    assign line_n    = {1'b0, r_line_count} + 1'b1;
    assign line_end  = r_prev_cr && i_q_item.is_lf;
    assign line_long = !line_end && (line_n >= limit);

    // size digits: stop at the first non-hex byte, freeze after overflow
    assign digit_take    = r_hex_active && i_q_item.hex_ok && !r_size_ovf;
    assign acc_over      = (r_acc[SIZE_BITS-1 -: 4] != 4'd0);
    assign ovf_next      = r_size_ovf || (digit_take && acc_over);
    assign acc_next      = (digit_take && !acc_over) ?
                           {r_acc[SIZE_BITS-5:0], i_q_item.hex_val} : r_acc;
    assign remaining_dec = r_remaining - 1'b1;

    // next phase and failure code
    always_comb begin
        n_phase = r_phase;
        n_fail  = r_fail;
        if (pop) begin
            unique case (i_q_item.op)
                OP_RESTART: begin
                    n_phase = PH_SIZE;
                    n_fail  = ST_BUSY;
                end
                OP_CLOSE: begin
                    if (r_phase != PH_DONE && r_phase != PH_FAIL) begin
                        n_phase = PH_FAIL;
                        n_fail  = ST_CLOSED;
                    end
                end
                OP_DATA: begin
                    unique case (r_phase)
                        PH_SIZE: begin
                            if (line_end) begin
                                if (ovf_next) begin
                                    n_phase = PH_FAIL;
                                    n_fail  = ST_OVERFLOW;
                                end else if (acc_next == '0) begin
                                    n_phase = PH_TRAILER;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end else if (line_long) begin
                                n_phase = PH_FAIL;
                                n_fail  = ST_LONG;
                            end
                        end
                        PH_DATA: begin
                            if (remaining_dec == '0) begin
                                n_phase = PH_CRLF;
                            end
                        end
                        PH_CRLF: begin
                            if (r_line_count != '0) begin
                                if (r_first_bad || !i_q_item.is_lf) begin
                                    n_phase = PH_FAIL;
                                    n_fail  = ST_BADCRLF;
                                end else begin
                                    n_phase = PH_SIZE;
                                end
                            end
                        end
                        PH_TRAILER: begin
                            if (line_end) begin
                                if (line_n == (LINE_BITS+1)'(2)) begin
                                    n_phase = PH_DONE;
                                end
                            end else if (line_long) begin
                                n_phase = PH_FAIL;
                                n_fail  = ST_LONG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // line, size and count registers plus the result fields
    always_comb begin
        n_line_count = r_line_count;
        n_prev_cr    = r_prev_cr;
        n_hex_active = r_hex_active;
        n_size_ovf   = r_size_ovf;
        n_acc        = r_acc;
        n_remaining  = r_remaining;
        n_first_bad  = r_first_bad;
        n_written    = r_written;
        out_byte     = 8'd0;
        out_flag     = 1'b0;
        if (pop) begin
            unique case (i_q_item.op)
                OP_RESTART: begin
                    n_line_count = '0;
                    n_prev_cr    = 1'b0;
                    n_hex_active = 1'b1;
                    n_size_ovf   = 1'b0;
                    n_acc        = '0;
                    n_remaining  = '0;
                    n_first_bad  = 1'b0;
                    n_written    = '0;
                end
                OP_DATA: begin
                    unique case (r_phase)
                        PH_SIZE: begin
                            n_hex_active = r_hex_active && i_q_item.hex_ok;
                            n_size_ovf   = ovf_next;
                            n_acc        = acc_next;
                            if (line_end) begin
                                if (!ovf_next) begin
                                    if (acc_next != '0) begin
                                        n_remaining = acc_next;
                                    end
                                    n_line_count = '0;
                                    n_prev_cr    = 1'b0;
                                    n_hex_active = 1'b1;
                                    n_size_ovf   = 1'b0;
                                    n_acc        = '0;
                                end
                            end else if (!line_long) begin
                                n_line_count = line_n[LINE_BITS-1:0];
                                n_prev_cr    = i_q_item.is_cr;
                            end
                        end
                        PH_DATA: begin
                            out_byte    = i_q_item.data;
                            out_flag    = 1'b1;
                            n_remaining = remaining_dec;
                            if (r_written != '1) begin
                                n_written = r_written + 1'b1;
                            end
                            if (remaining_dec == '0) begin
                                n_line_count = '0;
                                n_first_bad  = 1'b0;
                            end
                        end
                        PH_CRLF: begin
                            if (r_line_count == '0) begin
                                n_first_bad  = !i_q_item.is_cr;
                                n_line_count = LINE_BITS'(1);
                            end else if (!(r_first_bad || !i_q_item.is_lf)) begin
                                n_line_count = '0;
                                n_prev_cr    = 1'b0;
                                n_hex_active = 1'b1;
                                n_size_ovf   = 1'b0;
                                n_acc        = '0;
                                n_first_bad  = 1'b0;
                            end
                        end
                        PH_TRAILER: begin
                            if (line_end) begin
                                if (line_n != (LINE_BITS+1)'(2)) begin
                                    n_line_count = '0;
                                    n_prev_cr    = 1'b0;
                                    n_hex_active = 1'b1;
                                    n_size_ovf   = 1'b0;
                                    n_acc        = '0;
                                end
                            end else if (!line_long) begin
                                n_line_count = line_n[LINE_BITS-1:0];
                                n_prev_cr    = i_q_item.is_cr;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        if (n_phase == PH_DONE) begin
            status = ST_DONE;
        end else if (n_phase == PH_FAIL) begin
            status = n_fail;
        end else begin
            status = ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_fail       <= ST_BUSY;
            r_line_count <= '0;
            r_prev_cr    <= 1'b0;
            r_hex_active <= 1'b1;
            r_size_ovf   <= 1'b0;
            r_acc        <= '0;
            r_remaining  <= '0;
            r_first_bad  <= 1'b0;
            r_written    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_fail       <= n_fail;
            r_line_count <= n_line_count;
            r_prev_cr    <= n_prev_cr;
            r_hex_active <= n_hex_active;
            r_size_ovf   <= n_size_ovf;
            r_acc        <= n_acc;
            r_remaining  <= n_remaining;
            r_first_bad  <= n_first_bad;
            r_written    <= n_written;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data <= OUT_TDATA_BITS'({n_written[31:0], status, out_byte});
            r_out_user <= out_flag;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_q_item.op == OP_RESTART |=> r_phase == PH_SIZE && r_written == '0)
        else $error("restart did not clear the parser");

    a_data_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remaining != '0)
        else $error("payload phase with nothing left");

    a_written_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && i_q_item.op == OP_RESTART) |=> r_written >= $past(r_written))
        else $error("byte count went backwards");

    a_crlf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_CRLF |-> r_line_count <= LINE_BITS'(1))
        else $error("trailing CRLF counter out of range");

endmodule
